// ===== sv/reservoir_sampler_with_deletes_top_macros.svh =====
// assertion macros for the reservoir sampler
`ifndef RESERVOIR_SAMPLER_WITH_DELETES_TOP_MACROS_SVH
`define RESERVOIR_SAMPLER_WITH_DELETES_TOP_MACROS_SVH
// property that holds each clock outside reset
`define RSD_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked each clock outside reset
`define RSD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

// ===== sv/rsd_pkg.sv =====
// shared types and codes of the reservoir sampler
package rsd_pkg;
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_ERASE  = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic [3:0] OUT_TO_SAMPLE   = 4'd0;
   localparam logic [3:0] OUT_TO_RESERVE  = 4'd1;
   localparam logic [3:0] OUT_SWAPPED     = 4'd2;
   localparam logic [3:0] OUT_REFILLED    = 4'd3;
   localparam logic [3:0] OUT_UNREFILLED  = 4'd4;
   localparam logic [3:0] OUT_ERASED_RES  = 4'd5;
   localparam logic [3:0] OUT_NOT_FOUND   = 4'd6;
   localparam logic [3:0] OUT_FULL_DROP   = 4'd7;
   localparam logic [3:0] OUT_CLEARED     = 4'd8;

   // shared divider control
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] remainder;
   } div_rsp_type;
endpackage

// ===== sv/rsd_ram.sv =====
// generic ram with one write port and one registered read port
module rsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== sv/rsd_div.sv =====
// bit serial remainder unit, one quotient bit per cycle
module rsd_div (
   input  logic                      clock,
   input  logic                      reset,
   input  rsd_pkg::div_req_type      req,
   output rsd_pkg::div_rsp_type      rsp
);
   import rsd_pkg::*;

   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;

   // restoring step
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[31:0], quo_ff[31]};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], 1'b0};
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
         end else begin
            rem_in = shifted;
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff[31:0];
endmodule

// ===== sv/reservoir_sampler_with_deletes_top.sv =====
// Reservoir sampler with deletions: one item at a time under a sequencer.
// Insert: to the sample, dropped, to the reserve, or swapped with a sample slot after
// waiting on the shared remainder unit for the slot.
// Erase: searches entries one at a time and shifts those after the hit; a refill from the
// reserve waits on the shared remainder unit. Clear empties both stores.
// Result waits in an output register until taken; next item accepted the cycle after.
// Reset (synchronous, active high) empties both stores and sets k to 8.
module reservoir_sampler_with_deletes_top #(
   parameter int SAMPLE_MAX    = 64,
   parameter int RESERVE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_element,
   input  logic [31:0] req_accept_draw,
   input  logic [31:0] req_index_draw,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_outcome,
   output logic [31:0] rsp_moved_element,
   output logic [5:0]  rsp_slot,
   output logic [6:0]  rsp_sample_count,
   output logic [10:0] rsp_reserve_count,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);
   import rsd_pkg::*;
   `include "reservoir_sampler_with_deletes_top_macros.svh"

   localparam int SA = (SAMPLE_MAX > 1) ? $clog2(SAMPLE_MAX) : 1;
   localparam int RA = (RESERVE_DEPTH > 1) ? $clog2(RESERVE_DEPTH) : 1;
   localparam int SC = $clog2(SAMPLE_MAX + 1);
   localparam int RC = $clog2(RESERVE_DEPTH + 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_INS, ST_ACC_MUL, ST_ACC_CMP, ST_SW_DIV, ST_SW_RD, ST_SW_WR,
      ST_S_SRCH, ST_S_CHK, ST_S_SHRD, ST_S_SHWR, ST_RF_DIV, ST_RF_RD,
      ST_RF_WR, ST_R_SRCH, ST_R_CHK, ST_R_SHRD, ST_R_SHWR, ST_DONE
   } state_type;

   state_type   state_ff;
   logic [6:0]  ksize_ff;
   logic [SC-1:0] sfill_ff;
   logic [RC-1:0] rfill_ff;
   logic [31:0] elem_ff, adraw_ff, idraw_ff;
   logic [RC-1:0] ptr_ff;
   logic        refill_ff;
   logic [63:0] lhs_ff;
   logic        out_v_ff;
   logic [3:0]  out_o_ff;
   logic [31:0] out_m_ff;
   logic [5:0]  out_s_ff;
   logic [SC-1:0] rslot_ff;
   logic        div_wait_ff;

   // effective k
   logic [SC-1:0] keff;
   always_comb begin
      if (ksize_ff == 7'd0) keff = SC'(1);
      else if ({25'd0, ksize_ff} > 32'(SAMPLE_MAX)) keff = SC'(SAMPLE_MAX);
      else keff = SC'(ksize_ff);
   end

   // memories
   logic s_we, r_we;
   logic [SA-1:0] s_wa, s_ra;
   logic [RA-1:0] r_wa, r_ra;
   logic [31:0] s_wd, r_wd, s_rd, r_rd;
   rsd_ram #(.WIDTH(32), .DEPTH(SAMPLE_MAX)) u_sram (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd));
   rsd_ram #(.WIDTH(32), .DEPTH(RESERVE_DEPTH)) u_rram (
      .clock(clock), .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd),
      .rd_addr(r_ra), .rd_data(r_rd));

   // shared divider
   div_req_type dreq;
   div_rsp_type drsp;
   rsd_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign req_stall = (state_ff != ST_IDLE) || out_v_ff;

   // memory addressing and divider requests
   always_comb begin
      s_we = 1'b0; r_we = 1'b0;
      s_wa = SA'(ptr_ff); r_wa = RA'(ptr_ff);
      s_wd = elem_ff; r_wd = elem_ff;
      s_ra = SA'(ptr_ff); r_ra = RA'(ptr_ff);
      dreq.start = 1'b0; dreq.dividend = idraw_ff; dreq.divisor = 32'(keff);
      case (state_ff)
         ST_INS: begin
            if (sfill_ff < keff) begin
               s_we = 1'b1; s_wa = SA'(sfill_ff);
            end else if (32'(rfill_ff) < 32'(RESERVE_DEPTH)) begin
               r_we = 1'b1; r_wa = RA'(rfill_ff);
            end
         end
         ST_SW_RD: s_ra = SA'(rslot_ff);
         ST_SW_WR: begin
            s_we = 1'b1; s_wa = SA'(rslot_ff);
            r_we = 1'b1; r_wa = RA'(rfill_ff - RC'(1)); r_wd = s_rd;
         end
         ST_ACC_CMP: begin
            // k*(2^32-1) as k*2^32 - k
            dreq.start = (lhs_ff < ((64'(keff) << 32) - 64'(keff)));
         end
         ST_S_SHRD: s_ra = SA'(ptr_ff + RC'(1));
         ST_S_SHWR: begin
            s_we = 1'b1; s_wd = s_rd;
         end
         ST_RF_DIV: begin
            dreq.start = !div_wait_ff; dreq.divisor = 32'(rfill_ff);
         end
         ST_RF_RD: r_ra = RA'(drsp.remainder);
         ST_RF_WR: begin
            s_we = 1'b1; s_wa = SA'(sfill_ff); s_wd = r_rd;
         end
         ST_R_SHRD: r_ra = RA'(ptr_ff + RC'(1));
         ST_R_SHWR: begin
            r_we = 1'b1; r_wd = r_rd;
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ksize_ff <= 7'd8;
         sfill_ff <= '0;
         rfill_ff <= '0;
         out_v_ff <= 1'b0;
         div_wait_ff <= 1'b0;
      end else begin
         if (csr_wr_en) ksize_ff <= csr_wr_data;
         if (out_v_ff && !rsp_stall) out_v_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && !req_stall && req_command != CMD_NONE) begin
                  elem_ff <= req_element;
                  adraw_ff <= req_accept_draw; idraw_ff <= req_index_draw;
                  out_m_ff <= '0; out_s_ff <= '0; ptr_ff <= '0;
                  case (req_command)
                     CMD_INSERT: state_ff <= ST_INS;
                     CMD_ERASE:  state_ff <= ST_S_SRCH;
                     default: begin
                        sfill_ff <= '0; rfill_ff <= '0;
                        out_o_ff <= OUT_CLEARED; state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_INS: begin
               if (sfill_ff < keff) begin
                  sfill_ff <= sfill_ff + SC'(1);
                  out_o_ff <= OUT_TO_SAMPLE; state_ff <= ST_DONE;
               end else if (32'(rfill_ff) >= 32'(RESERVE_DEPTH)) begin
                  out_o_ff <= OUT_FULL_DROP; state_ff <= ST_DONE;
               end else begin
                  rfill_ff <= rfill_ff + RC'(1); state_ff <= ST_ACC_MUL;
               end
            end
            ST_ACC_MUL: begin
               lhs_ff <= 64'(adraw_ff) * 64'(32'(keff) + 32'(rfill_ff));
               state_ff <= ST_ACC_CMP;
            end
            ST_ACC_CMP: begin
               if (dreq.start) state_ff <= ST_SW_DIV;
               else begin
                  out_o_ff <= OUT_TO_RESERVE; state_ff <= ST_DONE;
               end
            end
            ST_SW_DIV: if (drsp.done) begin
               rslot_ff <= SC'(drsp.remainder); state_ff <= ST_SW_RD;
            end
            ST_SW_RD: state_ff <= ST_SW_WR;
            ST_SW_WR: begin
               out_m_ff <= s_rd; out_s_ff <= 6'(rslot_ff);
               out_o_ff <= OUT_SWAPPED; state_ff <= ST_DONE;
            end
            // sample search: read issued, check next cycle
            ST_S_SRCH: begin
               if (ptr_ff >= RC'(sfill_ff)) begin
                  ptr_ff <= '0; state_ff <= ST_R_SRCH;
               end else state_ff <= ST_S_CHK;
            end
            ST_S_CHK: begin
               if (s_rd == elem_ff) state_ff <= ST_S_SHRD;
               else begin
                  ptr_ff <= ptr_ff + RC'(1); state_ff <= ST_S_SRCH;
               end
            end
            ST_S_SHRD: begin
               if (ptr_ff + RC'(1) >= RC'(sfill_ff)) begin
                  sfill_ff <= sfill_ff - SC'(1);
                  if (rfill_ff != '0) state_ff <= ST_RF_DIV;
                  else begin
                     out_o_ff <= OUT_UNREFILLED; state_ff <= ST_DONE;
                  end
               end else state_ff <= ST_S_SHWR;
            end
            ST_S_SHWR: begin
               ptr_ff <= ptr_ff + RC'(1); state_ff <= ST_S_SHRD;
            end
            ST_RF_DIV: begin
               if (drsp.done) begin
                  div_wait_ff <= 1'b0;
                  ptr_ff <= RC'(drsp.remainder); state_ff <= ST_RF_RD;
               end else begin
                  div_wait_ff <= 1'b1;
               end
            end
            ST_RF_RD: state_ff <= ST_RF_WR;
            ST_RF_WR: begin
               out_m_ff <= r_rd; sfill_ff <= sfill_ff + SC'(1);
               refill_ff <= 1'b1; state_ff <= ST_R_SHRD;
            end
            ST_R_SRCH: begin
               refill_ff <= 1'b0;
               if (ptr_ff >= rfill_ff) begin
                  out_o_ff <= OUT_NOT_FOUND; state_ff <= ST_DONE;
               end else state_ff <= ST_R_CHK;
            end
            ST_R_CHK: begin
               if (r_rd == elem_ff) state_ff <= ST_R_SHRD;
               else begin
                  ptr_ff <= ptr_ff + RC'(1); state_ff <= ST_R_SRCH;
               end
            end
            ST_R_SHRD: begin
               if (ptr_ff + RC'(1) >= rfill_ff) begin
                  rfill_ff <= rfill_ff - RC'(1);
                  out_o_ff <= refill_ff ? OUT_REFILLED : OUT_ERASED_RES;
                  state_ff <= ST_DONE;
               end else state_ff <= ST_R_SHWR;
            end
            ST_R_SHWR: begin
               ptr_ff <= ptr_ff + RC'(1); state_ff <= ST_R_SHRD;
            end
            ST_DONE: begin
               out_v_ff <= 1'b1; state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_outcome       = out_o_ff;
   assign rsp_moved_element = out_m_ff;
   assign rsp_slot          = out_s_ff;
   assign rsp_sample_count  = 7'(sfill_ff);
   assign rsp_reserve_count = 11'(rfill_ff);

   // checks
   `RSD_ASSERT_ALWAYS(a_sfill_max, clock, reset, 32'(sfill_ff) <= 32'(SAMPLE_MAX), "sample over")
   `RSD_ASSERT_ALWAYS(a_rfill_max, clock, reset, 32'(rfill_ff) <= 32'(RESERVE_DEPTH), "reserve over")
   `RSD_ASSERT_IMPLY(a_busy_stall, clock, reset, state_ff != ST_IDLE, req_stall, "ready while busy")
endmodule

// ===== tb/rsd_checker.sv =====
// checker for the reservoir sampler: tracks accepted items, predicts results and compares
`timescale 1ns / 1ps

module rsd_checker
   import rsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_element,
   input  logic [31:0] req_accept_draw,
   input  logic [31:0] req_index_draw,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_outcome,
   input  logic [31:0] rsp_moved_element,
   input  logic [5:0]  rsp_slot,
   input  logic [6:0]  rsp_sample_count,
   input  logic [10:0] rsp_reserve_count,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   output int          failures,
   output int          pending
);
   localparam int SAMPLE_MAX    = 64;
   localparam int RESERVE_DEPTH = 1024;

   typedef struct packed {
      logic [3:0]  outcome;
      logic [31:0] moved;
      logic [5:0]  slot;
      logic [6:0]  sample_count;
      logic [10:0] reserve_count;
   } step_result_t;

   step_result_t expected_results[$];

   // mirror of the block's stores and register
   logic [31:0] sample_ids  [SAMPLE_MAX];
   logic [31:0] reserve_ids [RESERVE_DEPTH];
   int          sample_fill;
   int          reserve_fill;
   logic [6:0]  target_size;

   function automatic int target_k();
      if (target_size == 0) return 1;
      if (target_size > SAMPLE_MAX) return SAMPLE_MAX;
      return int'(target_size);
   endfunction

   // apply one command to the mirror and return the result it should give
   function automatic step_result_t apply_command(logic [1:0] cmd, logic [31:0] id,
                                                  logic [31:0] adraw, logic [31:0] idraw);
      step_result_t r;
      int k;
      int pos;
      int ridx;
      logic [63:0] lhs;
      logic [63:0] rhs;
      logic [31:0] evicted;
      r = '0;
      k = target_k();
      pos = -1;
      if (cmd == CMD_INSERT) begin
         if (sample_fill < k) begin
            sample_ids[sample_fill] = id;
            sample_fill++;
            r.outcome = OUT_TO_SAMPLE;
         end else if (reserve_fill >= RESERVE_DEPTH) begin
            r.outcome = OUT_FULL_DROP;
         end else begin
            reserve_ids[reserve_fill] = id;
            reserve_fill++;
            lhs = {32'd0, adraw} * 64'(k + reserve_fill);
            rhs = 64'(k) * 64'hFFFF_FFFF;
            if (lhs < rhs) begin
               r.slot = 6'(idraw % 32'(k));
               evicted = sample_ids[idraw % 32'(k)];
               sample_ids[idraw % 32'(k)] = id;
               reserve_ids[reserve_fill - 1] = evicted;
               r.moved = evicted;
               r.outcome = OUT_SWAPPED;
            end else begin
               r.outcome = OUT_TO_RESERVE;
            end
         end
      end else if (cmd == CMD_ERASE) begin
         for (int i = 0; i < sample_fill; i++)
            if (pos < 0 && sample_ids[i] == id) pos = i;
         if (pos >= 0) begin
            for (int i = pos; i + 1 < sample_fill; i++) sample_ids[i] = sample_ids[i + 1];
            sample_fill--;
            if (reserve_fill > 0) begin
               ridx = int'(idraw % 32'(reserve_fill));
               r.moved = reserve_ids[ridx];
               sample_ids[sample_fill] = reserve_ids[ridx];
               sample_fill++;
               for (int i = ridx; i + 1 < reserve_fill; i++) reserve_ids[i] = reserve_ids[i + 1];
               reserve_fill--;
               r.outcome = OUT_REFILLED;
            end else begin
               r.outcome = OUT_UNREFILLED;
            end
         end else begin
            for (int i = 0; i < reserve_fill; i++)
               if (pos < 0 && reserve_ids[i] == id) pos = i;
            if (pos >= 0) begin
               for (int i = pos; i + 1 < reserve_fill; i++) reserve_ids[i] = reserve_ids[i + 1];
               reserve_fill--;
               r.outcome = OUT_ERASED_RES;
            end else begin
               r.outcome = OUT_NOT_FOUND;
            end
         end
      end else begin
         sample_fill = 0;
         reserve_fill = 0;
         r.outcome = OUT_CLEARED;
      end
      r.sample_count  = 7'(sample_fill);
      r.reserve_count = 11'(reserve_fill);
      return r;
   endfunction

   assign pending = expected_results.size();

   // watch both channels and the register port
   always @(posedge clock) begin
      step_result_t want;
      step_result_t seen;
      if (reset) begin
         sample_fill  = 0;
         reserve_fill = 0;
         target_size  = 7'd8;
         failures     = 0;
         expected_results.delete();
      end else begin
         if (csr_wr_en) target_size = csr_wr_data;
         if (req_valid && !req_stall && req_command != CMD_NONE)
            expected_results.insert(expected_results.size(),
                                    apply_command(req_command, req_element,
                                                  req_accept_draw, req_index_draw));
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_outcome, rsp_moved_element, rsp_slot,
                    rsp_sample_count, rsp_reserve_count};
            if (expected_results.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected result: outcome %0d moved %h slot %0d counts %0d/%0d",
                           seen.outcome, seen.moved, seen.slot, seen.sample_count,
                           seen.reserve_count);
            end else begin
               want = expected_results.pop_front();
               if (want != seen) begin
                  failures++;
                  if (failures <= 10)
                     $display({"mismatch: expected outcome %0d moved %h slot %0d counts %0d/%0d,",
                               " got outcome %0d moved %h slot %0d counts %0d/%0d"},
                              want.outcome, want.moved, want.slot, want.sample_count,
                              want.reserve_count, seen.outcome, seen.moved, seen.slot,
                              seen.sample_count, seen.reserve_count);
               end
            end
         end
      end
   end
endmodule

// ===== tb/tb.sv =====
// testbench top for the reservoir sampler: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;
   import rsd_pkg::*;

   // longest erase walk and shift, plus margin
   localparam int SETTLE_CYCLES = 2400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_NONE;
   logic [31:0] req_element = '0;
   logic [31:0] req_accept_draw = '0;
   logic [31:0] req_index_draw = '0;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_outcome;
   logic [31:0] rsp_moved_element;
   logic [5:0]  rsp_slot;
   logic [6:0]  rsp_sample_count;
   logic [10:0] rsp_reserve_count;
   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_wr_data = '0;
   int          failures;
   int          pending;
   int          stall_left = 0;
   bit          quiet = 1'b0;
   logic [31:0] live_ids[$];

   reservoir_sampler_with_deletes_top uut (.*);

   rsd_checker check (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side stalls at random after each item taken, not at all while quiet
   assign rsp_stall = (stall_left != 0);
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left <= quiet ? 0 : $urandom_range(0, 14);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // offer one item after a random gap and hold it until accepted
   task automatic send_item(logic [1:0] cmd, logic [31:0] id, logic [31:0] adraw,
                            logic [31:0] idraw);
      int gap;
      if ($urandom_range(0, 19) == 0) quiet = !quiet;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_element     <= id;
      req_accept_draw <= adraw;
      req_index_draw  <= idraw;
      do @(posedge clock); while (req_stall);
      if (cmd == CMD_INSERT) live_ids.insert(live_ids.size(), id);
      if (cmd == CMD_CLEAR) live_ids.delete();
   endtask

   // wait for all results, let the block settle, then write the size register
   task automatic write_size(logic [6:0] k);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_item();
      logic [1:0]  cmd;
      logic [31:0] id;
      logic [31:0] adraw;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) cmd = CMD_INSERT;
      else if (pick < 92) cmd = CMD_ERASE;
      else if (pick < 96) cmd = CMD_CLEAR;
      else cmd = CMD_NONE;
      id = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
      if (cmd == CMD_ERASE && live_ids.size() > 0 && $urandom_range(0, 9) < 7)
         id = live_ids[$urandom_range(0, live_ids.size() - 1)];
      adraw = ($urandom_range(0, 2) == 0) ? ($urandom >> $urandom_range(0, 31)) : $urandom;
      send_item(cmd, id, adraw, $urandom);
   endtask

   initial begin
      logic [6:0] sizes[7] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd6, 7'd2, 7'd8};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fill the sample, swap and reserve, erase cases, ignored and clear
      send_item(CMD_INSERT, 32'h0000_0000, 32'h0, 32'h0);
      send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 32'd5, 32'h0, 32'h0);
      send_item(CMD_INSERT, 32'd5, 32'h0, 32'h0);
      send_item(CMD_INSERT, 32'd7, 32'h0, 32'h0);
      send_item(CMD_INSERT, 32'd9, 32'h0, 32'h0);
      send_item(CMD_INSERT, 32'd10, 32'h0, 32'h0);
      send_item(CMD_INSERT, 32'd11, 32'h0, 32'h0);
      send_item(CMD_INSERT, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 32'hCAFE_0000, 32'hFFFF_FFFF, 32'h0);
      send_item(CMD_INSERT, 32'hCAFE_0001, 32'hFFFF_FFFF, 32'h0);
      send_item(CMD_INSERT, 32'hCAFE_0002, 32'h7FFF_FFFF, 32'h5555_5555);
      send_item(CMD_ERASE, 32'd5, 32'h0, 32'hFFFF_FFFF);
      send_item(CMD_ERASE, 32'hCAFE_0001, 32'h0, 32'h0);
      send_item(CMD_ERASE, 32'hDEAD_BEEF, 32'h0, 32'h0);
      send_item(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_CLEAR, 32'h0, 32'h0, 32'h0);
      send_item(CMD_INSERT, 32'd1, 32'h0, 32'h0);
      send_item(CMD_ERASE, 32'd1, 32'h0, 32'h0);
      send_item(CMD_ERASE, 32'd1, 32'h0, 32'h0);

      // random phases across sizes; the sample keeps entries when k shrinks
      foreach (sizes[p]) begin
         write_size(sizes[p]);
         repeat (38) random_item();
      end

      // a few more random items, then clear
      repeat (4) random_item();
      send_item(CMD_CLEAR, 32'h0, 32'h0, 32'h0);

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // timeout
   initial begin
      #100ms;
      $display("tb NOT OK");
      $finish;
   end
endmodule
